>>> design/yrc_pkg.sv
// Shared types, constants and the pixel clamp for the 4:2:0 to RGB converter.
// Used by every module of the block through scoped names; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package yrc_pkg;

  // Configuration register port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_PAIRS_PER_ROW  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_FRAME = 4'd1;

  // Geometry
  localparam int PAIRS_W = 12;
  localparam int ROWS_W  = 13;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam logic [PAIRS_W-1:0] PAIRS_RESET = 12'd320;
  localparam logic [PAIRS_W-1:0] MAX_PAIRS   = 12'd2048;
  localparam logic [ROWS_W-1:0]  ROWS_RESET  = 13'd480;
  localparam logic [ROWS_W-1:0]  MAX_ROWS    = 13'd4096;

  // Sample widths
  localparam int Y_W      = 8;
  localparam int CHROMA_W = 10;

  // BT.601 integer coefficients, chroma weighted by four
  localparam int C_RV    = 409;
  localparam int C_GU    = 100;
  localparam int C_GV    = 208;
  localparam int C_BU    = 516;
  localparam int C_Y2    = 298 * 8;
  localparam int K_RED   = (128*4 - 16*298*4 - 409*512);
  localparam int K_GREEN = (128*4 - 16*298*4 + 100*512 + 208*512);
  localparam int K_BLUE  = (128*4 - 16*298*4 - 516*512);

  localparam int COEF_W = 21;
  localparam int SUM_W  = 23;
  localparam int OUT_SHIFT = 11;

  // Queues
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = 2;
  localparam int JOBQ_CNT_W = 3;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // One accepted pair, with the held pair it releases
  typedef struct packed {
    logic [Y_W-1:0]      held_yl;
    logic [Y_W-1:0]      held_yr;
    logic [CHROMA_W-1:0] held_cu;
    logic [CHROMA_W-1:0] held_cv;
    logic [Y_W-1:0]      cur_yl;
    logic [Y_W-1:0]      cur_yr;
    logic [CHROMA_W-1:0] cu;
    logic [CHROMA_W-1:0] cv;
    logic                emit_held;
    logic                emit_cur;
    logic                last_row;
  } job_t;

  typedef struct packed {
    logic [7:0] red_left;
    logic [7:0] green_left;
    logic [7:0] blue_left;
    logic [7:0] red_right;
    logic [7:0] green_right;
    logic [7:0] blue_right;
    logic       row_end;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Sum is twice the 10-bit-scaled value; drop the fraction and clamp to 0..255
  function automatic logic [7:0] clamp_px(sum_t s);
    sum_t sh;
    sh = s >>> OUT_SHIFT;
    if (s < 0) begin
      return 8'd0;
    end else if (sh > 255) begin
      return 8'd255;
    end else begin
      return sh[7:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/yrc_front.sv
// Front end: configuration registers, column/row counters, vertical chroma
// weighting and the held pair. Emits one job per pair that releases results.
// Depends on yrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yrc_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr,
  input  wire logic [yrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [yrc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           accept,
  input  wire logic [7:0]                     luma_left,
  input  wire logic [7:0]                     luma_right,
  input  wire logic [7:0]                     u_near,
  input  wire logic [7:0]                     u_other,
  input  wire logic [7:0]                     v_near,
  input  wire logic [7:0]                     v_other,
  output yrc_pkg::job_t                       job,
  output logic                                job_valid
);

  logic [yrc_pkg::PAIRS_W-1:0]  pairs_per_row;
  logic [yrc_pkg::ROWS_W-1:0]   rows_per_frame;
  logic [yrc_pkg::COL_W-1:0]    column_count;
  logic [yrc_pkg::ROW_W-1:0]    row_count;
  logic [yrc_pkg::Y_W-1:0]      held_luma_left;
  logic [yrc_pkg::Y_W-1:0]      held_luma_right;
  logic [yrc_pkg::CHROMA_W-1:0] held_u_weighted;
  logic [yrc_pkg::CHROMA_W-1:0] held_v_weighted;

  logic [yrc_pkg::PAIRS_W-1:0]  pairs_eff;
  logic [yrc_pkg::PAIRS_W-1:0]  last_col_pos;
  logic [yrc_pkg::ROWS_W-1:0]   rows_even;
  logic [yrc_pkg::ROWS_W-1:0]   rows_eff;
  logic [yrc_pkg::ROWS_W-1:0]   last_row_pos;
  logic                         last_col;
  logic                         last_row;
  logic                         at_edge;
  logic [yrc_pkg::CHROMA_W-1:0] cu;
  logic [yrc_pkg::CHROMA_W-1:0] cv;

  always_comb begin
    if (pairs_per_row == '0) begin
      pairs_eff = yrc_pkg::PAIRS_W'(1);
    end else if (pairs_per_row > yrc_pkg::MAX_PAIRS) begin
      pairs_eff = yrc_pkg::MAX_PAIRS;
    end else begin
      pairs_eff = pairs_per_row;
    end
    last_col_pos = pairs_eff - yrc_pkg::PAIRS_W'(1);

    rows_even = {rows_per_frame[yrc_pkg::ROWS_W-1:1], 1'b0};
    if (rows_even < yrc_pkg::ROWS_W'(2)) begin
      rows_eff = yrc_pkg::ROWS_W'(2);
    end else if (rows_even > yrc_pkg::MAX_ROWS) begin
      rows_eff = yrc_pkg::MAX_ROWS;
    end else begin
      rows_eff = rows_even;
    end
    last_row_pos = rows_eff - yrc_pkg::ROWS_W'(1);

    // a count left past its end by a register change counts as the end
    last_col = {1'b0, column_count} >= last_col_pos;
    last_row = {1'b0, row_count} >= last_row_pos;

    // top row and bottom odd row use the near chroma row alone
    at_edge = row_count[0] ? last_row : (row_count == '0);
    if (at_edge) begin
      cu = {u_near, 2'b00};
      cv = {v_near, 2'b00};
    end else begin
      cu = {2'b00, u_near} + {1'b0, u_near, 1'b0} + {2'b00, u_other};
      cv = {2'b00, v_near} + {1'b0, v_near, 1'b0} + {2'b00, v_other};
    end
  end

  always_comb begin
    job.held_yl   = held_luma_left;
    job.held_yr   = held_luma_right;
    job.held_cu   = held_u_weighted;
    job.held_cv   = held_v_weighted;
    job.cur_yl    = luma_left;
    job.cur_yr    = luma_right;
    job.cu        = cu;
    job.cv        = cv;
    job.emit_held = column_count != '0;
    job.emit_cur  = last_col;
    job.last_row  = last_row;
    job_valid     = accept && (job.emit_held || job.emit_cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_per_row  <= yrc_pkg::PAIRS_RESET;
      rows_per_frame <= yrc_pkg::ROWS_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        yrc_pkg::REG_PAIRS_PER_ROW:  pairs_per_row  <= cfg_data[yrc_pkg::PAIRS_W-1:0];
        yrc_pkg::REG_ROWS_PER_FRAME: rows_per_frame <= cfg_data[yrc_pkg::ROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      held_luma_left  <= '0;
      held_luma_right <= '0;
      held_u_weighted <= '0;
      held_v_weighted <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + yrc_pkg::ROW_W'(1);
      end else begin
        // hold the pair until the next column's chroma arrives
        held_luma_left  <= luma_left;
        held_luma_right <= luma_right;
        held_u_weighted <= cu;
        held_v_weighted <= cv;
        column_count    <= column_count + yrc_pkg::COL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/yrc_job_queue.sv
// Short job queue between the front end and the color back end.
// Register storage read only at the head. Depends on yrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yrc_job_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire yrc_pkg::job_t wr_job,
  input  wire logic          pop,
  output yrc_pkg::job_t      head,
  output yrc_pkg::q_status_t stat
);

  yrc_pkg::job_t                  slots [yrc_pkg::JOBQ_DEPTH];
  logic [yrc_pkg::JOBQ_PTR_W-1:0] wr_ptr;
  logic [yrc_pkg::JOBQ_PTR_W-1:0] rd_ptr;
  logic [yrc_pkg::JOBQ_CNT_W-1:0] count;
  logic                           do_push;
  logic                           do_pop;

  assign stat.full  = count == yrc_pkg::JOBQ_CNT_W'(yrc_pkg::JOBQ_DEPTH);
  assign stat.empty = count == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + yrc_pkg::JOBQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + yrc_pkg::JOBQ_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + yrc_pkg::JOBQ_CNT_W'(1);
        2'b01:   count <= count - yrc_pkg::JOBQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/yrc_back.sv
// Back end: expands each job into one or two pixel-pair results, runs the
// color products, sums and clamps, and buffers results in an output queue.
// Depends on yrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yrc_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire yrc_pkg::job_t      job,
  input  wire yrc_pkg::q_status_t jq_stat,
  output logic                    job_pop,
  input  wire logic               pop,
  output yrc_pkg::pix_t           pix,
  output logic                    empty
);

  // issue side
  logic                         phase;
  logic                         issue;
  logic                         use_held;
  logic [yrc_pkg::Y_W-1:0]      op_yl;
  logic [yrc_pkg::Y_W-1:0]      op_yr;
  logic [yrc_pkg::CHROMA_W-1:0] op_cu;
  logic [yrc_pkg::CHROMA_W-1:0] op_cv;
  logic [yrc_pkg::CHROMA_W-1:0] op_nu;
  logic [yrc_pkg::CHROMA_W-1:0] op_nv;
  logic                         op_rend;
  logic                         op_fend;

  // product stage
  logic           s1_valid;
  yrc_pkg::coef_t s1_r0;
  yrc_pkg::coef_t s1_g0;
  yrc_pkg::coef_t s1_b0;
  yrc_pkg::coef_t s1_r1;
  yrc_pkg::coef_t s1_g1;
  yrc_pkg::coef_t s1_b1;
  yrc_pkg::coef_t s1_ylw;
  yrc_pkg::coef_t s1_yrw;
  logic           s1_rend;
  logic           s1_fend;

  // sum stage and output queue
  yrc_pkg::sum_t                  sum_rl;
  yrc_pkg::sum_t                  sum_gl;
  yrc_pkg::sum_t                  sum_bl;
  yrc_pkg::sum_t                  sum_rr;
  yrc_pkg::sum_t                  sum_gr;
  yrc_pkg::sum_t                  sum_br;
  yrc_pkg::pix_t                  res;
  yrc_pkg::pix_t                  outq [yrc_pkg::OUTQ_DEPTH];
  logic [yrc_pkg::OUTQ_PTR_W-1:0] wr_ptr;
  logic [yrc_pkg::OUTQ_PTR_W-1:0] rd_ptr;
  logic [yrc_pkg::OUTQ_CNT_W-1:0] count;
  logic                           do_pop;

  always_comb begin
    // reserve a queue slot for every result still in the product stage
    issue    = !jq_stat.empty &&
               (int'(count) + int'(s1_valid) < yrc_pkg::OUTQ_DEPTH);
    use_held = job.emit_held && !phase;
    job_pop  = issue && (!(job.emit_held && job.emit_cur) || phase);
    if (use_held) begin
      op_yl   = job.held_yl;
      op_yr   = job.held_yr;
      op_cu   = job.held_cu;
      op_cv   = job.held_cv;
      op_nu   = job.cu;
      op_nv   = job.cv;
      op_rend = 1'b0;
      op_fend = 1'b0;
    end else begin
      op_yl   = job.cur_yl;
      op_yr   = job.cur_yr;
      op_cu   = job.cu;
      op_cv   = job.cv;
      op_nu   = job.cu;
      op_nv   = job.cv;
      op_rend = 1'b1;
      op_fend = job.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (issue) begin
        phase <= !job_pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_r0   <= yrc_pkg::coef_t'(yrc_pkg::C_RV * int'(op_cv) + yrc_pkg::K_RED);
    s1_g0   <= yrc_pkg::coef_t'(yrc_pkg::K_GREEN - yrc_pkg::C_GU * int'(op_cu)
                                - yrc_pkg::C_GV * int'(op_cv));
    s1_b0   <= yrc_pkg::coef_t'(yrc_pkg::C_BU * int'(op_cu) + yrc_pkg::K_BLUE);
    s1_r1   <= yrc_pkg::coef_t'(yrc_pkg::C_RV * int'(op_nv) + yrc_pkg::K_RED);
    s1_g1   <= yrc_pkg::coef_t'(yrc_pkg::K_GREEN - yrc_pkg::C_GU * int'(op_nu)
                                - yrc_pkg::C_GV * int'(op_nv));
    s1_b1   <= yrc_pkg::coef_t'(yrc_pkg::C_BU * int'(op_nu) + yrc_pkg::K_BLUE);
    s1_ylw  <= yrc_pkg::coef_t'(yrc_pkg::C_Y2 * int'(op_yl));
    s1_yrw  <= yrc_pkg::coef_t'(yrc_pkg::C_Y2 * int'(op_yr));
    s1_rend <= op_rend;
    s1_fend <= op_fend;
  end

  always_comb begin
    // left pixel is doubled so both pixels share one shift and clamp
    sum_rl = yrc_pkg::sum_t'(s1_r0) + yrc_pkg::sum_t'(s1_r0) + yrc_pkg::sum_t'(s1_ylw);
    sum_gl = yrc_pkg::sum_t'(s1_g0) + yrc_pkg::sum_t'(s1_g0) + yrc_pkg::sum_t'(s1_ylw);
    sum_bl = yrc_pkg::sum_t'(s1_b0) + yrc_pkg::sum_t'(s1_b0) + yrc_pkg::sum_t'(s1_ylw);
    sum_rr = yrc_pkg::sum_t'(s1_r0) + yrc_pkg::sum_t'(s1_r1) + yrc_pkg::sum_t'(s1_yrw);
    sum_gr = yrc_pkg::sum_t'(s1_g0) + yrc_pkg::sum_t'(s1_g1) + yrc_pkg::sum_t'(s1_yrw);
    sum_br = yrc_pkg::sum_t'(s1_b0) + yrc_pkg::sum_t'(s1_b1) + yrc_pkg::sum_t'(s1_yrw);
    res.red_left    = yrc_pkg::clamp_px(sum_rl);
    res.green_left  = yrc_pkg::clamp_px(sum_gl);
    res.blue_left   = yrc_pkg::clamp_px(sum_bl);
    res.red_right   = yrc_pkg::clamp_px(sum_rr);
    res.green_right = yrc_pkg::clamp_px(sum_gr);
    res.blue_right  = yrc_pkg::clamp_px(sum_br);
    res.row_end     = s1_rend;
    res.frame_end   = s1_fend;
  end

  assign empty  = count == '0;
  assign do_pop = pop && !empty;
  assign pix    = outq[rd_ptr];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      outq[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= wr_ptr + yrc_pkg::OUTQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + yrc_pkg::OUTQ_PTR_W'(1);
      end
      case ({s1_valid, do_pop})
        2'b10:   count <= count + yrc_pkg::OUTQ_CNT_W'(1);
        2'b01:   count <= count - yrc_pkg::OUTQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/yuv420_to_rgb_converter_core.sv
// BT.601 planar 4:2:0 to RGB converter, top level.
// Instantiates yrc_front, yrc_job_queue and yrc_back; depends on yrc_pkg.
//
// Usage:
//   Input queue: drive one luma pair with its near/other U and V samples and
//   raise push; the pair is taken at an edge with push high and full low.
//   Result queue: while empty is low the oldest result pair sits on the
//   color ports with row_end/frame_end; pop high takes it.
//   Config: cfg_valid with cfg_index/cfg_data; cfg_ready is always high.
//   Index 0 is pairs_per_row, index 1 rows_per_frame, other indexes ignored.
// Timing:
//   A pair is released once the next pair of its row arrives; the last pair
//   of a row releases itself too. A released result passes the job queue,
//   product stage and result queue. Input rate is one pair per cycle unless
//   full; the back end retires one result per cycle while the result queue
//   has room, and the four-entry job queue absorbs the row-end double result.
// Reset: counters, held pair and both queues clear; the registers return to
//   320 pairs and 480 rows.
// Stall: with pop low the four-entry result queue fills, the back end stops,
//   the job queue fills and full rises; no result is dropped.
`timescale 1ns / 1ps
`default_nettype none

module yuv420_to_rgb_converter_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [yrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [yrc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     luma_left,
  input  wire logic [7:0]                     luma_right,
  input  wire logic [7:0]                     u_near,
  input  wire logic [7:0]                     u_other,
  input  wire logic [7:0]                     v_near,
  input  wire logic [7:0]                     v_other,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          red_left,
  output logic [7:0]                          green_left,
  output logic [7:0]                          blue_left,
  output logic [7:0]                          red_right,
  output logic [7:0]                          green_right,
  output logic [7:0]                          blue_right,
  output logic                                row_end,
  output logic                                frame_end
);

  yrc_pkg::job_t      job_in;
  yrc_pkg::job_t      job_head;
  yrc_pkg::q_status_t jq_stat;
  yrc_pkg::pix_t      pix;
  logic               job_push;
  logic               job_pop;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign full      = jq_stat.full;
  assign accept    = push && !full;

  yrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .luma_left  (luma_left),
    .luma_right (luma_right),
    .u_near     (u_near),
    .u_other    (u_other),
    .v_near     (v_near),
    .v_other    (v_other),
    .job        (job_in),
    .job_valid  (job_push)
  );

  yrc_job_queue u_job_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (job_in),
    .pop    (job_pop),
    .head   (job_head),
    .stat   (jq_stat)
  );

  yrc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .job     (job_head),
    .jq_stat (jq_stat),
    .job_pop (job_pop),
    .pop     (pop),
    .pix     (pix),
    .empty   (empty)
  );

  assign red_left    = pix.red_left;
  assign green_left  = pix.green_left;
  assign blue_left   = pix.blue_left;
  assign red_right   = pix.red_right;
  assign green_right = pix.green_right;
  assign blue_right  = pix.blue_right;
  assign row_end     = pix.row_end;
  assign frame_end   = pix.frame_end;

  // a frame ends only on the last pair of a row
  assert property (@(posedge clk) disable iff (rst) (!empty && frame_end) |-> row_end)
    else $error("frame_end without row_end at the result head");

  // both queues come out of reset drained
  assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queues not drained after reset");

endmodule

`default_nettype wire
